// ===== sv/vfc_pkg.sv =====
// ============================================================================
// vfc_pkg
// Shared types, codes and atlas tables of the voxel face cull mesher.
// ============================================================================
package vfc_pkg;

    // Field widths fixed by the item format
    localparam int IDX_W      = 12;
    localparam int IDX_SPAN   = 2 ** IDX_W;
    localparam int TYPE_W     = 3;
    localparam int POS_W      = 4;
    localparam int DIR_W      = 3;
    localparam int COL_W      = 2;
    // Coordinate field wide enough for the largest supported chunk edge
    localparam int CRD_W      = 6;

    // Defaults handed to the top level
    localparam int CHUNK_EDGE_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [TYPE_W-1:0] {
        BT_NONE   = 3'd0,
        BT_BLACK  = 3'd1,
        BT_GREEN  = 3'd2,
        BT_GREY   = 3'd3,
        BT_ORANGE = 3'd4,
        BT_PURPLE = 3'd5,
        BT_RED    = 3'd6
    } t_block;

    typedef enum logic [DIR_W-1:0] {
        FD_NEG_X = 3'd0,
        FD_POS_X = 3'd1,
        FD_NEG_Y = 3'd2,
        FD_POS_Y = 3'd3,
        FD_NEG_Z = 3'd4,
        FD_POS_Z = 3'd5
    } t_face_dir;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL_X,
        FS_FIX_X,
        FS_MUL_Y,
        FS_FIX_Y,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_SELF,
        BS_NBR,
        BS_EMIT
    } t_back_state;

    // Classified item travelling from front to back
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [TYPE_W-1:0] btype;
        logic [CRD_W-1:0]  x;
        logic [CRD_W-1:0]  y;
        logic [CRD_W-1:0]  z;
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One result record
    typedef struct packed {
        logic              has_face;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [DIR_W-1:0]  face_dir;
        logic [COL_W-1:0]  tile_col;
        logic              tile_row;
        logic              last;
    } t_face_rec;

    // Atlas column of a voxel type
    function automatic logic [COL_W-1:0] tile_col_of(input logic [TYPE_W-1:0] bt);
        logic [COL_W-1:0] col;
        case (bt)
            BT_BLACK, BT_ORANGE: col = 2'd2;
            BT_GREEN, BT_PURPLE: col = 2'd1;
            default:             col = 2'd0;
        endcase
        return col;
    endfunction

    // Atlas row of a voxel type
    function automatic logic tile_row_of(input logic [TYPE_W-1:0] bt);
        logic row;
        case (bt)
            BT_ORANGE, BT_PURPLE, BT_RED: row = 1'b1;
            default:                      row = 1'b0;
        endcase
        return row;
    endfunction

endpackage

// ===== sv/vfc_if.sv =====
// ============================================================================
// vfc_if
// Valid/ready channels for voxel items and face records.
// ============================================================================
interface vfc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [vfc_pkg::IDX_W-1:0]  voxel_index;
    logic [vfc_pkg::TYPE_W-1:0] block_type;

    modport source (output valid, op, voxel_index, block_type, input ready);
    modport sink   (input valid, op, voxel_index, block_type, output ready);
endinterface

interface vfc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      has_face;
    logic [vfc_pkg::POS_W-1:0] pos_x;
    logic [vfc_pkg::POS_W-1:0] pos_y;
    logic [vfc_pkg::POS_W-1:0] pos_z;
    logic [vfc_pkg::DIR_W-1:0] face_dir;
    logic [vfc_pkg::COL_W-1:0] tile_col;
    logic                      tile_row;
    logic                      last;

    modport source (output valid, has_face, pos_x, pos_y, pos_z, face_dir,
                    tile_col, tile_row, last, input ready);
    modport sink   (input valid, has_face, pos_x, pos_y, pos_z, face_dir,
                    tile_col, tile_row, last, output ready);
endinterface

// ===== sv/vfc_ram.sv =====
// ============================================================================
// vfc_ram
// Single-port RAM with registered read.
// ============================================================================
module vfc_ram #(
    parameter int W     = 3,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vfc_queue.sv =====
// ============================================================================
// vfc_queue
// Small command FIFO between the classifier and the face unit.
// ============================================================================
module vfc_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vfc_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output vfc_pkg::t_cmd   o_head,
    output vfc_pkg::t_q_stat o_stat
);
    import vfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== sv/vfc_front.sv =====
// ============================================================================
// vfc_front
// Accepts items, splits a query index into chunk coordinates, queues it.
// ============================================================================
module vfc_front #(
    parameter int CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clearing,
    vfc_in_if.sink           i_in,
    input  vfc_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output vfc_pkg::t_cmd    o_cmd
);
    import vfc_pkg::*;

    // Reciprocal of the edge, scaled by the index span
    localparam int RECIP = IDX_SPAN / CHUNK_EDGE;
    localparam int PROD_W = 2 * IDX_W;
    localparam int REM_W = IDX_W + 1;

    t_front_state r_state, n_state;
    t_cmd         r_cmd, n_cmd;
    logic [IDX_W-1:0] r_q, n_q;
    logic [IDX_W-1:0] r_q0, n_q0;

    logic              accept;
    logic [IDX_W-1:0]  div_in;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] qe;
    logic [REM_W-1:0]  rem;
    logic              corr;
    logic [IDX_W-1:0]  q_fix;
    logic [REM_W-1:0]  r_fix;

    assign accept = i_in.valid && i_in.ready;

    // Shared divide-by-edge unit: estimate, then one correction step
    always_comb begin
        div_in = (r_state == FS_MUL_Y || r_state == FS_FIX_Y) ? r_q : r_cmd.idx;
        prod   = PROD_W'(div_in) * PROD_W'(RECIP);
        qe     = PROD_W'(r_q0) * PROD_W'(CHUNK_EDGE);
        rem    = REM_W'(div_in) - REM_W'(qe);
        corr   = (rem >= REM_W'(CHUNK_EDGE));
        q_fix  = r_q0 + IDX_W'(corr);
        r_fix  = corr ? rem - REM_W'(CHUNK_EDGE) : rem;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    n_state = (i_in.op == OP_QUERY) ? FS_MUL_X : FS_PUSH;
                end
            end
            FS_MUL_X: n_state = FS_FIX_X;
            FS_FIX_X: n_state = FS_MUL_Y;
            FS_MUL_Y: n_state = FS_FIX_Y;
            FS_FIX_Y: n_state = FS_PUSH;
            FS_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // Outputs and datapath loads
    always_comb begin
        i_in.ready = 1'b0;
        o_push     = 1'b0;
        n_cmd      = r_cmd;
        n_q        = r_q;
        n_q0       = r_q0;
        unique case (r_state)
            FS_IDLE: begin
                i_in.ready = !i_clearing;
                if (accept) begin
                    n_cmd.op    = i_in.op;
                    n_cmd.idx   = i_in.voxel_index;
                    n_cmd.btype = i_in.block_type;
                end
            end
            FS_MUL_X, FS_MUL_Y: begin
                n_q0 = prod[PROD_W-1:IDX_W];
            end
            FS_FIX_X: begin
                n_cmd.x = CRD_W'(r_fix);
                n_q     = q_fix;
            end
            FS_FIX_Y: begin
                n_cmd.y = CRD_W'(r_fix);
                n_cmd.z = CRD_W'(q_fix);
            end
            FS_PUSH: begin
                o_push = !i_q_stat.full;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_q   <= n_q;
        r_q0  <= n_q0;
    end

    assign o_cmd = r_cmd;

endmodule

// ===== sv/vfc_back.sv =====
// ============================================================================
// vfc_back
// Owns the voxel store: clears it, applies writes, culls faces of queries.
// ============================================================================
module vfc_back #(
    parameter int CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vfc_pkg::t_cmd    i_head,
    input  vfc_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_clearing,
    vfc_out_if.source        o_out
);
    import vfc_pkg::*;

    localparam int CELLS = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int DEPTH = (CELLS < IDX_SPAN) ? CELLS : IDX_SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = IDX_W + 2;
    localparam int NFACE = 6;

    t_back_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    t_cmd             r_cmd, n_cmd;
    logic [DIR_W-1:0] r_dir, n_dir;
    logic             r_ok, n_ok;
    logic [NFACE-1:0] r_mask, n_mask;
    logic [TYPE_W-1:0] r_type, n_type;
    logic             r_out_valid, n_out_valid;
    t_face_rec        r_out, n_out;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [TYPE_W-1:0] ram_wdata;
    logic [TYPE_W-1:0] ram_rdata;
    logic [TYPE_W-1:0] cur_type;
    logic              head_ok;
    logic [DIR_W-1:0]  nb_dir;
    logic [NW-1:0]     nb_idx;
    logic              nb_ok;
    logic [DIR_W-1:0]  low_dir;
    logic [NFACE-1:0]  low_hot;
    logic [NFACE-1:0]  rest;
    logic              out_free;

    vfc_ram #(
        .W     (TYPE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign head_ok  = (NW'(i_head.idx) < NW'(DEPTH));
    assign cur_type = r_ok ? ram_rdata : TYPE_W'(BT_NONE);
    assign out_free = !r_out_valid || o_out.ready;

    // Neighbor address and bounds for the direction being read
    always_comb begin
        logic [NW-1:0] base;
        base   = NW'(r_cmd.idx);
        nb_dir = (r_state == BS_NBR) ? r_dir + DIR_W'(1) : FD_NEG_X;
        nb_idx = base;
        nb_ok  = 1'b0;
        case (nb_dir)
            FD_NEG_X: begin
                nb_idx = base - NW'(1);
                nb_ok  = (r_cmd.x != '0);
            end
            FD_POS_X: begin
                nb_idx = base + NW'(1);
                nb_ok  = (r_cmd.x != CRD_W'(CHUNK_EDGE - 1)) && (nb_idx < NW'(DEPTH));
            end
            FD_NEG_Y: begin
                nb_idx = base - NW'(CHUNK_EDGE);
                nb_ok  = (r_cmd.y != '0);
            end
            FD_POS_Y: begin
                nb_idx = base + NW'(CHUNK_EDGE);
                nb_ok  = (r_cmd.y != CRD_W'(CHUNK_EDGE - 1)) && (nb_idx < NW'(DEPTH));
            end
            FD_NEG_Z: begin
                nb_idx = base - NW'(CHUNK_EDGE * CHUNK_EDGE);
                nb_ok  = (r_cmd.z != '0);
            end
            FD_POS_Z: begin
                nb_idx = base + NW'(CHUNK_EDGE * CHUNK_EDGE);
                nb_ok  = (r_cmd.z != CRD_W'(CHUNK_EDGE - 1)) && (nb_idx < NW'(DEPTH));
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // Pick the lowest exposed direction still pending
    always_comb begin
        low_dir = '0;
        low_hot = '0;
        for (int i = NFACE - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_dir = DIR_W'(i);
                low_hot = NFACE'(1) << i;
            end
        end
        rest = r_mask & ~low_hot;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_q_stat.empty && i_head.op == OP_QUERY) begin
                    n_state = BS_SELF;
                end
            end
            BS_SELF: n_state = (cur_type == TYPE_W'(BT_NONE)) ? BS_EMIT : BS_NBR;
            BS_NBR: begin
                if (r_dir == FD_POS_Z) begin
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (out_free && rest == '0) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Store access, queue pop and result loads
    always_comb begin
        ram_we      = 1'b0;
        ram_addr    = nb_idx[AW-1:0];
        ram_wdata   = i_head.btype;
        o_pop       = 1'b0;
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_dir       = r_dir;
        n_ok        = r_ok;
        n_mask      = r_mask;
        n_type      = r_type;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (r_state)
            BS_CLEAR: begin
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                ram_wdata  = TYPE_W'(BT_NONE);
                n_clr_addr = r_clr_addr + AW'(1);
            end
            BS_IDLE: begin
                ram_addr = i_head.idx[AW-1:0];
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    n_ok  = head_ok;
                    // Drop writes beyond the chunk
                    ram_we = (i_head.op == OP_WRITE) && head_ok;
                end
            end
            BS_SELF: begin
                n_mask = '0;
                n_type = cur_type;
                n_dir  = FD_NEG_X;
                n_ok   = nb_ok;
            end
            BS_NBR: begin
                n_mask[r_dir] = !(r_ok && ram_rdata != TYPE_W'(BT_NONE));
                n_dir         = r_dir + DIR_W'(1);
                n_ok          = nb_ok;
            end
            BS_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_mask == '0) begin
                        n_out      = '0;
                        n_out.last = 1'b1;
                    end else begin
                        n_out.has_face = 1'b1;
                        n_out.pos_x    = POS_W'(r_cmd.x);
                        n_out.pos_y    = POS_W'(r_cmd.y);
                        n_out.pos_z    = POS_W'(r_cmd.z);
                        n_out.face_dir = low_dir;
                        n_out.tile_col = tile_col_of(r_type);
                        n_out.tile_row = tile_row_of(r_type);
                        n_out.last     = (rest == '0);
                        n_mask         = rest;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_dir  <= n_dir;
        r_ok   <= n_ok;
        r_mask <= n_mask;
        r_type <= n_type;
        r_out  <= n_out;
    end

    assign o_clearing     = (r_state == BS_CLEAR);
    assign o_out.valid    = r_out_valid;
    assign o_out.has_face = r_out.has_face;
    assign o_out.pos_x    = r_out.pos_x;
    assign o_out.pos_y    = r_out.pos_y;
    assign o_out.pos_z    = r_out.pos_z;
    assign o_out.face_dir = r_out.face_dir;
    assign o_out.tile_col = r_out.tile_col;
    assign o_out.tile_row = r_out.tile_row;
    assign o_out.last     = r_out.last;

endmodule

// ===== sv/voxel_face_cull_mesher.sv =====
// ============================================================================
// voxel_face_cull_mesher
// Culled face meshing over one cubic chunk of voxel types.
// ============================================================================
// A write item stores a voxel type; a query item returns one face record per
// empty or out-of-chunk neighbor of an occupied voxel, in the order -x, +x,
// -y, +y, -z, +z, or a single empty record when nothing is visible, with
// last set on the final record. The front takes a write through its accept
// and push states, and a query through the accept state, the MUL_X, FIX_X,
// MUL_Y and FIX_Y states that split the index into coordinates with a shared
// reciprocal multiplier, and the push state into a two-entry queue, so front
// and back overlap. The back owns the single-port voxel store and pops one
// command at a time. A write is applied in the pop state. A query of an
// empty or out-of-chunk voxel goes through pop and read, check, and one
// empty record. A query of an occupied voxel goes through pop and read of
// the voxel, its check, reads of the six neighbors one at a time through the
// store port, then the face records one at a time; a result channel that
// holds off stalls them. A full queue holds the front in its push state.
// After reset the back clears all min(CHUNK_EDGE^3, 4096) entries of the
// store, during which no input is taken.
// ============================================================================
module voxel_face_cull_mesher #(
    parameter int CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfc_in_if.sink    i_in,
    vfc_out_if.source o_out
);
    import vfc_pkg::*;

    t_cmd    front_cmd;
    t_cmd    q_head;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;
    logic    clearing;

    vfc_front #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clearing (clearing),
        .i_in       (i_in),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    vfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    vfc_back #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_stat   (q_stat),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

    // No input transfer while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !i_in.ready)
        else $error("input accepted during store clear");

    // Never push into a full queue, never pop an empty one
    a_queue_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
        else $error("queue overrun or underrun");

    // An empty record always closes its query
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_face) |-> o_out.last)
        else $error("empty record without last");

    // A face record names one of the six directions
    a_face_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_face) |-> (o_out.face_dir <= FD_POS_Z))
        else $error("face direction out of range");

endmodule
